// File: rtl/mbss_pkg.sv
// shared types and constants for the masked byte signature scan
`timescale 1ns / 1ps
package mbss_pkg;

  // signature storage is fixed by the two 64-bit pattern registers
  localparam int SIG_BYTES = 16;
  localparam int PADDR_W   = 6;
  localparam int REG_IDX_W = 3;

  // register indexes, taken from paddr[5:3]
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CARE_MASK      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BASE_ADDRESS   = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] match_address;
  } out_item_t;

  typedef struct packed {
    logic [63:0] pattern_low;
    logic [63:0] pattern_high;
    logic [15:0] care_mask;
    logic [4:0]  pattern_length;
    logic [31:0] base_address;
  } cfg_t;

  // outcome of one byte step
  typedef struct packed {
    logic      emit;
    out_item_t item;
  } step_res_t;

endpackage

// File: rtl/masked_byte_signature_scan_core.sv
// Masked byte signature scan: top level with input and result registers
//
// Bytes of a memory range enter on the in channel (valid/ready), one word per
// byte in ascending address order, with last on the final byte. Each byte
// shifts into a window of MAX_PATTERN_BYTES bytes and the newest
// pattern_length bytes are compared with the signature; clear care_mask bits
// are wildcards. The first match of a scan gives one out word with found set
// and its start address; a scan with no match gives found clear on its last
// byte. Nothing else is produced.
// Path: an accepted byte is held in the input register, and its result goes
// into the result register when that slot is free or draining.
// Throughput: one byte per cycle while results are taken; the window compare
// is a single pass of parallel byte equalities between the input and result
// registers. When out_ready is low with a result pending, the input register
// holds and in_ready falls once it is full.
// Reset (rst, synchronous) clears the scan state, empties both pipeline registers
// and sets the configuration registers to zero but pattern_length, which is 1.
// Configuration is written through the apb-style port at byte address 8*index;
// the user must write it only with the block idle, which is not enforced.
`timescale 1ns / 1ps
module masked_byte_signature_scan_core
  import mbss_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  cfg_t      cfg;
  step_res_t res;
  logic      held_valid;
  in_item_t  held;
  logic      advance;

  assign pready = 1'b1;

  mbss_cfg_regs u_cfg (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (psel && penable && pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .cfg    (cfg)
  );

  mbss_window_match #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_match (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (advance),
    .data_byte (held.data_byte),
    .last      (held.last),
    .res       (res)
  );

  // a held word moves on when the result slot is free or draining
  assign advance  = held_valid && (!out_valid || out_ready);
  assign in_ready = !held_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      held <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res.item;
    end
  end

`ifndef ASSERT_OFF
  // a not-found word carries a zero address
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.match_address == 32'd0)
    else $error("not-found word with nonzero address");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> held_valid && out_valid && !out_ready)
    else $error("input stalled without a pending result");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !held_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule

// File: rtl/mbss_cfg_regs.sv
// configuration register file behind the apb-style port
`timescale 1ns / 1ps
module mbss_cfg_regs
  import mbss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output cfg_t               cfg
);

  logic [REG_IDX_W-1:0] idx;

  assign idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_low    <= '0;
      cfg.pattern_high   <= '0;
      cfg.care_mask      <= '0;
      cfg.pattern_length <= 5'd1;
      cfg.base_address   <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_PATTERN_LOW:    cfg.pattern_low    <= pwdata;
        REG_PATTERN_HIGH:   cfg.pattern_high   <= pwdata;
        REG_CARE_MASK:      cfg.care_mask      <= pwdata[15:0];
        REG_PATTERN_LENGTH: cfg.pattern_length <= pwdata[4:0];
        REG_BASE_ADDRESS:   cfg.base_address   <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // read-back
  always_comb begin
    unique case (idx)
      REG_PATTERN_LOW:    prdata = cfg.pattern_low;
      REG_PATTERN_HIGH:   prdata = cfg.pattern_high;
      REG_CARE_MASK:      prdata = {48'd0, cfg.care_mask};
      REG_PATTERN_LENGTH: prdata = {59'd0, cfg.pattern_length};
      REG_BASE_ADDRESS:   prdata = {32'd0, cfg.base_address};
      default:            prdata = '0;
    endcase
  end

endmodule

// File: rtl/mbss_window_match.sv
// byte window, scan state and masked signature compare
`timescale 1ns / 1ps
module mbss_window_match
  import mbss_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last,
  output step_res_t  res
);

  localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);

  logic [7:0]       window      [MAX_PATTERN_BYTES];
  logic [7:0]       window_next [MAX_PATTERN_BYTES];
  logic [7:0]       sig         [SIG_BYTES];
  logic [31:0]      bytes_seen;
  logic [31:0]      bytes_seen_next;
  logic             already_found;
  logic [LEN_W-1:0] eff_len;
  logic             mismatch;
  logic             hit;

  // effective length, clamped to 1..MAX_PATTERN_BYTES
  always_comb begin
    if (cfg.pattern_length == 5'd0) begin
      eff_len = LEN_W'(1);
    end else if (cfg.pattern_length > 5'(MAX_PATTERN_BYTES)) begin
      eff_len = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      eff_len = LEN_W'(cfg.pattern_length);
    end
  end

  // signature bytes, byte 0 in the low bits of pattern_low
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      sig[k]     = cfg.pattern_low[k*8 +: 8];
      sig[k + 8] = cfg.pattern_high[k*8 +: 8];
    end
  end

  // window after taking the incoming byte
  always_comb begin
    window_next[0] = data_byte;
    for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
      window_next[i] = window[i-1];
    end
  end

  assign bytes_seen_next = (bytes_seen == '1) ? bytes_seen : bytes_seen + 32'd1;

  // window position pos pairs with signature byte eff_len-1-pos
  always_comb begin
    logic [4:0] k;
    mismatch = 1'b0;
    for (int pos = 0; pos < MAX_PATTERN_BYTES; pos++) begin
      k = 5'(eff_len) - 5'(pos) - 5'd1;
      if ((5'(pos) < 5'(eff_len)) && cfg.care_mask[k[3:0]] &&
          (window_next[pos] != sig[k[3:0]])) begin
        mismatch = 1'b1;
      end
    end
  end

  assign hit = !already_found && (bytes_seen_next >= 32'(eff_len)) && !mismatch;

  // result of this step
  always_comb begin
    res.emit               = hit || (!already_found && last);
    res.item.found         = hit;
    res.item.match_address = hit ?
        cfg.base_address + (bytes_seen_next - 32'(eff_len)) : 32'd0;
  end

  // scan state, cleared at the end of every scan
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen    <= '0;
      already_found <= 1'b0;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) window[i] <= '0;
    end else if (step) begin
      if (last) begin
        bytes_seen    <= '0;
        already_found <= 1'b0;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) window[i] <= '0;
      end else begin
        bytes_seen    <= bytes_seen_next;
        already_found <= already_found || hit;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) window[i] <= window_next[i];
      end
    end
  end

`ifndef ASSERT_OFF
  // a reported match always has at least one byte behind it
  a_found_has_bytes: assert property (@(posedge clk) disable iff (rst)
    already_found |-> bytes_seen != 32'd0)
    else $error("match flag set with no bytes seen");

  // a second hit in one scan is never reported
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    already_found |-> !res.emit)
    else $error("result after a match in the same scan");
`endif

endmodule

// File: tb/tb_masked_byte_signature_scan_core.sv
// self-checking testbench for the masked byte signature scan core
`timescale 1ns / 1ps
module tb_masked_byte_signature_scan_core
  import mbss_pkg::*;
();

  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned SETTLE_WAIT  = 4;
  localparam int unsigned DRAIN_LIMIT  = 5000;
  localparam logic [63:0] DIR_SIG_LOW  = 64'hFF00_7F80_0102_A55A;
  localparam logic [63:0] DIR_SIG_HIGH = 64'h0010_FE01_C3E7_00FF;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [63:0]       pwdata = '0;
  logic [63:0]       prdata;
  logic              pready;

  // predictor copy of the registers and the scan state
  logic [63:0] sig_low = '0;
  logic [63:0] sig_high = '0;
  logic [15:0] care_bits = '0;
  logic [4:0]  len_field = 5'd1;
  logic [31:0] base_addr = '0;
  logic [7:0]  scan_window [SIG_BYTES] = '{default: 8'h00};
  logic [31:0] bytes_seen = '0;
  logic        hit_reported = 1'b0;

  in_item_t    pending_words [$];
  out_item_t   scan_outcomes [$];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned src_gap = 0;
  int unsigned sink_wait = 0;
  int unsigned hold_left = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_seen = 0;
  bit          src_gappy = 1'b0;
  bit          sink_gappy = 1'b0;

  masked_byte_signature_scan_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // bytes of signature in use, with the length clamped to 1..16
  function automatic int unsigned span_len();
    if (len_field == 5'd0) return 1;
    if (len_field > SIG_BYTES) return SIG_BYTES;
    return 32'(len_field);
  endfunction

  function automatic int unsigned draw_gap(bit gappy);
    if (!gappy) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
  endfunction

  // shift one accepted byte into the window and work out its outcome
  task automatic scan_byte(input in_item_t w);
    int unsigned n;
    bit hit;
    out_item_t r;
    logic [127:0] sig;
    n = span_len();
    sig = {sig_high, sig_low};
    for (int i = SIG_BYTES - 1; i > 0; i--) scan_window[i] = scan_window[i-1];
    scan_window[0] = w.data_byte;
    if (bytes_seen != 32'hFFFF_FFFF) bytes_seen++;
    if (!hit_reported) begin
      hit = (bytes_seen >= n);
      for (int k = 0; k < n; k++) begin
        if (care_bits[k] && scan_window[n-1-k] != sig[8*k +: 8]) hit = 1'b0;
      end
      if (hit) begin
        r.found = 1'b1;
        r.match_address = base_addr + bytes_seen - n;
        scan_outcomes.insert(scan_outcomes.size(), r);
        hit_reported = 1'b1;
      end else if (w.last) begin
        r = '0;
        scan_outcomes.insert(scan_outcomes.size(), r);
      end
    end
    // end of scan clears the window for the next range
    if (w.last) begin
      scan_window = '{default: 8'h00};
      bytes_seen = '0;
      hit_reported = 1'b0;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (scan_outcomes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result word: found=%0b addr=%h", got.found, got.match_address);
    end else begin
      want = scan_outcomes.pop_front();
      if (got.found !== want.found || got.match_address !== want.match_address) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected found=%0b addr=%h, got found=%0b addr=%h",
                   want.found, want.match_address, got.found, got.match_address);
      end
    end
  endtask

  // input driver: pops the next word after its gap and holds it until taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (in_valid && in_ready) scan_byte(in_data);
      if (!in_valid || in_ready) begin
        if (src_gap != 0) begin
          in_valid <= 1'b0;
          src_gap <= src_gap - 1;
        end else if (pending_words.size() != 0) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
          src_gap <= draw_gap(src_gappy);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls, including the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_result(out_data);
        sink_wait = draw_gap(sink_gappy);
      end
      if (holds_seen != holds_asked) begin
        holds_seen = holds_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (sink_wait != 0) begin
        sink_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // register write: setup cycle then access cycle
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PATTERN_LOW:    sig_low = value;
      REG_PATTERN_HIGH:   sig_high = value;
      REG_CARE_MASK:      care_bits = value[15:0];
      REG_PATTERN_LENGTH: len_field = value[4:0];
      REG_BASE_ADDRESS:   base_addr = value[31:0];
      default: ;
    endcase
  endtask

  task automatic offer(input logic [7:0] b, input logic l);
    in_item_t w;
    w.data_byte = b;
    w.last = l;
    pending_words.insert(pending_words.size(), w);
  endtask

  // wait until every word is taken and every result has come back
  task automatic drain();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || scan_outcomes.size() != 0);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_pattern();
    case ($urandom_range(0, 5))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic random_config(input bit every_reg);
    logic [15:0] m;
    logic [4:0] l;
    logic [31:0] a;
    if (every_reg || $urandom_range(0, 1)) write_reg(REG_PATTERN_LOW, pick_pattern());
    if (every_reg || $urandom_range(0, 1)) write_reg(REG_PATTERN_HIGH, pick_pattern());
    if (every_reg || $urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 4))
        0: m = 16'hFFFF;
        1: m = 16'h0000;
        default: m = 16'($urandom_range(0, 65535));
      endcase
      write_reg(REG_CARE_MASK, {48'h0, m});
    end
    if (every_reg || $urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 7))
        0: l = 5'd0;
        1: l = 5'd31;
        2: l = 5'd16;
        3: l = 5'd1;
        4: l = 5'($urandom_range(17, 30));
        default: l = 5'($urandom_range(2, 15));
      endcase
      write_reg(REG_PATTERN_LENGTH, {59'h0, l});
    end
    if (every_reg || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 3))
        0: a = 32'h0;
        1: a = 32'hFFFF_FFFF;
        2: a = 32'hFFFF_FF00 | $urandom_range(0, 255);
        default: a = $urandom();
      endcase
      write_reg(REG_BASE_ADDRESS, {32'h0, a});
    end
  endtask

  // one scanned range: mostly a planted signature with random wildcard bytes,
  // some with a spoilt cared byte, some plain noise or too short to match
  task automatic queue_scan(input bit terminated, inout int unsigned count);
    int unsigned n, total, start, k, pick, spoil_at;
    bit planted, spoil;
    logic [7:0] b;
    logic [127:0] sig;
    n = span_len();
    sig = {sig_high, sig_low};
    pick = $urandom_range(0, 19);
    planted = (pick < 14);
    spoil = (pick >= 11 && pick < 14);
    if (pick == 19)
      total = $urandom_range(1, n);
    else if ($urandom_range(0, 9) == 0)
      total = n + $urandom_range(0, 80);
    else
      total = n + $urandom_range(0, 12);
    start = (total >= n) ? $urandom_range(0, total - n) : 0;
    spoil_at = $urandom_range(0, n - 1);
    for (int p = 0; p < total; p++) begin
      b = 8'($urandom_range(0, 255));
      if (planted && total >= n && p >= start && p < start + n) begin
        k = p - start;
        if (care_bits[k]) begin
          b = sig[8*k +: 8];
          if (spoil && k == spoil_at) b = b ^ (8'h01 << $urandom_range(0, 7));
        end
      end
      offer(b, terminated && p == total - 1);
    end
    count += total;
  endtask

  // stimulus
  initial begin
    int unsigned random_items;
    int unsigned n_scans;
    int unsigned phase;
    int unsigned wait_cnt;
    logic [127:0] dsig;
    random_items = 0;
    phase = 0;
    dsig = {DIR_SIG_HIGH, DIR_SIG_LOW};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one wildcard byte matches at once, rest of scan is silent
    offer(8'h00, 1'b0);
    offer(8'hFF, 1'b1);
    drain();

    // full-length signature matched on the last byte, address wraps to zero
    write_reg(REG_PATTERN_LOW, DIR_SIG_LOW);
    write_reg(REG_PATTERN_HIGH, DIR_SIG_HIGH);
    write_reg(REG_CARE_MASK, 64'hFFFF);
    write_reg(REG_PATTERN_LENGTH, 64'd16);
    write_reg(REG_BASE_ADDRESS, 64'hFFFF_FFFF);
    offer(8'h55, 1'b0);
    for (int k = 0; k < SIG_BYTES; k++) offer(dsig[8*k +: 8], k == SIG_BYTES - 1);
    drain();

    // all wildcards but window never fills: not found
    write_reg(REG_CARE_MASK, 64'h0);
    offer(8'h80, 1'b0);
    offer(8'h7F, 1'b0);
    offer(8'h01, 1'b1);
    drain();

    // zero length acts as one byte
    write_reg(REG_PATTERN_LENGTH, 64'd0);
    offer(8'h80, 1'b1);
    drain();

    // random phases, each ending with everything drained
    while (random_items < RANDOM_ITEMS) begin
      random_config(phase == 0);
      src_gappy = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      sink_gappy = ($urandom_range(0, 3) != 0);
      n_scans = $urandom_range(2, 8);
      for (int s = 0; s < n_scans; s++)
        queue_scan(s != n_scans - 1 || $urandom_range(0, 4) != 0, random_items);
      if (phase == 1 || $urandom_range(0, 15) == 0) holds_asked++;
      drain();
      phase++;
    end

    // wind down
    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    wait_cnt = 0;
    while (scan_outcomes.size() != 0 && wait_cnt < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (8) @(posedge clk);
    if (scan_outcomes.size() != 0) begin
      mismatches += scan_outcomes.size();
      $display("%0d expected result words never arrived", scan_outcomes.size());
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
